// ----- rtl/srr_pkg.sv -----
// ============================================================================
// srr_pkg: shared types and tables for the Selling reflect/reduce block
// Holds the opcode map, the reflection permutations and the lane control
// words of the six reduction steps.
// ============================================================================
package srr_pkg;

    localparam int unsigned SCALAR_WIDTH_DEF = 32;
    localparam int unsigned NUM_SCALARS      = 6;
    localparam int unsigned NUM_REFLECT      = 24;
    localparam int unsigned NUM_STEPS        = 6;
    localparam int unsigned OPCODE_WIDTH     = 5;
    localparam int unsigned SIDX_WIDTH       = $clog2(NUM_SCALARS);
    localparam int unsigned STEP_IDX_WIDTH   = $clog2(NUM_STEPS);

    typedef logic [OPCODE_WIDTH-1:0] opcode_t;
    typedef logic [SIDX_WIDTH-1:0]   sidx_t;

    // Opcode map: reflections first, then the reduction steps.
    localparam opcode_t OPC_STEP_FIRST = opcode_t'(NUM_REFLECT);
    localparam opcode_t OPC_STEP_LAST  = opcode_t'(NUM_REFLECT + NUM_STEPS - 1);

    typedef enum logic [1:0] {
        LANE_PASS,
        LANE_ADD,
        LANE_SUB,
        LANE_NEG
    } lane_op_t;

    // One output lane: result = a op b, or a alone, or -b.
    typedef struct packed {
        lane_op_t op;
        sidx_t    a;
        sidx_t    b;
    } lane_ctl_t;

    // Source scalar of each output position, one row per reflection.
    localparam sidx_t PERM_TABLE [NUM_REFLECT][NUM_SCALARS] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5}, '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5},
        '{3'd0, 3'd2, 3'd1, 3'd3, 3'd5, 3'd4}, '{3'd5, 3'd3, 3'd1, 3'd2, 3'd0, 3'd4},
        '{3'd4, 3'd2, 3'd3, 3'd1, 3'd5, 3'd0}, '{3'd5, 3'd1, 3'd3, 3'd2, 3'd4, 3'd0},
        '{3'd1, 3'd0, 3'd2, 3'd4, 3'd3, 3'd5}, '{3'd3, 3'd4, 3'd2, 3'd0, 3'd1, 3'd5},
        '{3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3}, '{3'd5, 3'd4, 3'd0, 3'd2, 3'd1, 3'd3},
        '{3'd3, 3'd2, 3'd4, 3'd0, 3'd5, 3'd1}, '{3'd5, 3'd0, 3'd4, 3'd2, 3'd3, 3'd1},
        '{3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd4}, '{3'd3, 3'd5, 3'd1, 3'd0, 3'd2, 3'd4},
        '{3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3}, '{3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd3, 3'd1, 3'd5, 3'd0, 3'd4, 3'd2}, '{3'd4, 3'd0, 3'd5, 3'd1, 3'd3, 3'd2},
        '{3'd2, 3'd4, 3'd3, 3'd5, 3'd1, 3'd0}, '{3'd1, 3'd5, 3'd3, 3'd4, 3'd2, 3'd0},
        '{3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1}, '{3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1},
        '{3'd1, 3'd3, 3'd5, 3'd4, 3'd0, 3'd2}, '{3'd0, 3'd4, 3'd5, 3'd3, 3'd1, 3'd2}
    };

    // Lane control of the reduction steps one to six.
    localparam lane_ctl_t STEP_TABLE [NUM_STEPS][NUM_SCALARS] = '{
        '{'{LANE_NEG, 3'd0, 3'd0}, '{LANE_ADD, 3'd1, 3'd0}, '{LANE_ADD, 3'd4, 3'd0},
          '{LANE_SUB, 3'd3, 3'd0}, '{LANE_ADD, 3'd2, 3'd0}, '{LANE_ADD, 3'd5, 3'd0}},
        '{'{LANE_SUB, 3'd0, 3'd3}, '{LANE_ADD, 3'd1, 3'd3}, '{LANE_ADD, 3'd4, 3'd3},
          '{LANE_NEG, 3'd3, 3'd3}, '{LANE_ADD, 3'd2, 3'd3}, '{LANE_ADD, 3'd5, 3'd3}},
        '{'{LANE_ADD, 3'd0, 3'd1}, '{LANE_NEG, 3'd1, 3'd1}, '{LANE_ADD, 3'd3, 3'd1},
          '{LANE_ADD, 3'd2, 3'd1}, '{LANE_SUB, 3'd4, 3'd1}, '{LANE_ADD, 3'd5, 3'd1}},
        '{'{LANE_ADD, 3'd0, 3'd4}, '{LANE_SUB, 3'd1, 3'd4}, '{LANE_ADD, 3'd3, 3'd4},
          '{LANE_ADD, 3'd2, 3'd4}, '{LANE_NEG, 3'd4, 3'd4}, '{LANE_ADD, 3'd5, 3'd4}},
        '{'{LANE_ADD, 3'd0, 3'd2}, '{LANE_ADD, 3'd3, 3'd2}, '{LANE_NEG, 3'd2, 3'd2},
          '{LANE_ADD, 3'd1, 3'd2}, '{LANE_ADD, 3'd4, 3'd2}, '{LANE_SUB, 3'd5, 3'd2}},
        '{'{LANE_ADD, 3'd0, 3'd5}, '{LANE_ADD, 3'd3, 3'd5}, '{LANE_SUB, 3'd2, 3'd5},
          '{LANE_ADD, 3'd1, 3'd5}, '{LANE_ADD, 3'd4, 3'd5}, '{LANE_NEG, 3'd5, 3'd5}}
    };

endpackage

// ----- rtl/srr_if.sv -----
// ============================================================================
// srr_if: item channels of the Selling reflect/reduce block
// Input channel carries an opcode and six scalars; output channel carries
// six scalars and the saturation flag. Both use a valid/ready handshake.
// ============================================================================
interface srr_in_if #(
    parameter int unsigned SCALAR_WIDTH = srr_pkg::SCALAR_WIDTH_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic [srr_pkg::OPCODE_WIDTH-1:0]    opcode;
    logic signed [SCALAR_WIDTH-1:0]      scalar_in_0;
    logic signed [SCALAR_WIDTH-1:0]      scalar_in_1;
    logic signed [SCALAR_WIDTH-1:0]      scalar_in_2;
    logic signed [SCALAR_WIDTH-1:0]      scalar_in_3;
    logic signed [SCALAR_WIDTH-1:0]      scalar_in_4;
    logic signed [SCALAR_WIDTH-1:0]      scalar_in_5;

    modport source (
        output valid, opcode, scalar_in_0, scalar_in_1, scalar_in_2,
               scalar_in_3, scalar_in_4, scalar_in_5,
        input  ready
    );
    modport sink (
        input  valid, opcode, scalar_in_0, scalar_in_1, scalar_in_2,
               scalar_in_3, scalar_in_4, scalar_in_5,
        output ready
    );
endinterface

interface srr_out_if #(
    parameter int unsigned SCALAR_WIDTH = srr_pkg::SCALAR_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SCALAR_WIDTH-1:0] scalar_out_0;
    logic signed [SCALAR_WIDTH-1:0] scalar_out_1;
    logic signed [SCALAR_WIDTH-1:0] scalar_out_2;
    logic signed [SCALAR_WIDTH-1:0] scalar_out_3;
    logic signed [SCALAR_WIDTH-1:0] scalar_out_4;
    logic signed [SCALAR_WIDTH-1:0] scalar_out_5;
    logic                           saturated;

    modport source (
        output valid, scalar_out_0, scalar_out_1, scalar_out_2, scalar_out_3,
               scalar_out_4, scalar_out_5, saturated,
        input  ready
    );
    modport sink (
        input  valid, scalar_out_0, scalar_out_1, scalar_out_2, scalar_out_3,
               scalar_out_4, scalar_out_5, saturated,
        output ready
    );
endinterface

// ----- rtl/srr_step.sv -----
// ============================================================================
// srr_step: reflect/reduce datapath
// Decodes the opcode into six lane control words and runs six saturating
// add/subtract lanes over the registered input vector.
// ============================================================================
module srr_step #(
    parameter int unsigned SCALAR_WIDTH = srr_pkg::SCALAR_WIDTH_DEF
) (
    input  logic [srr_pkg::OPCODE_WIDTH-1:0] opcode,
    input  logic signed [SCALAR_WIDTH-1:0]   scalar_in  [srr_pkg::NUM_SCALARS],
    output logic signed [SCALAR_WIDTH-1:0]   scalar_out [srr_pkg::NUM_SCALARS],
    output logic                             saturated
);
    import srr_pkg::*;

    localparam logic [SCALAR_WIDTH-1:0] SMAX = {1'b0, {(SCALAR_WIDTH-1){1'b1}}};
    localparam logic [SCALAR_WIDTH-1:0] SMIN = {1'b1, {(SCALAR_WIDTH-1){1'b0}}};

    lane_ctl_t                      ctl      [NUM_SCALARS];
    logic [NUM_SCALARS-1:0]         lane_sat;
    logic [STEP_IDX_WIDTH-1:0]      step_idx;

    assign step_idx = STEP_IDX_WIDTH'(opcode - OPC_STEP_FIRST);

    always_comb
    begin
        for (int i = 0; i < NUM_SCALARS; i++)
        begin
            if (opcode < OPC_STEP_FIRST)
            begin
                ctl[i] = '{LANE_PASS, PERM_TABLE[opcode][i], sidx_t'(i)};
            end
            else if (opcode <= OPC_STEP_LAST)
            begin
                ctl[i] = STEP_TABLE[step_idx][i];
            end
            else
            begin
                // Unused opcodes leave the vector as it is.
                ctl[i] = '{LANE_PASS, sidx_t'(i), sidx_t'(i)};
            end
        end
    end

    // One extra bit holds every sum, difference and negation exactly; the
    // top two bits disagree exactly when the result left the scalar range.
    always_comb
    begin
        logic signed [SCALAR_WIDTH:0] op_a;
        logic signed [SCALAR_WIDTH:0] op_b;
        logic signed [SCALAR_WIDTH:0] wide;
        for (int i = 0; i < NUM_SCALARS; i++)
        begin
            op_a = {scalar_in[ctl[i].a][SCALAR_WIDTH-1], scalar_in[ctl[i].a]};
            op_b = {scalar_in[ctl[i].b][SCALAR_WIDTH-1], scalar_in[ctl[i].b]};
            case (ctl[i].op)
                LANE_ADD: wide = op_a + op_b;
                LANE_SUB: wide = op_a - op_b;
                LANE_NEG: wide = '0 - op_b;
                default:  wide = op_a;
            endcase
            lane_sat[i] = wide[SCALAR_WIDTH] != wide[SCALAR_WIDTH-1];
            if (lane_sat[i])
            begin
                scalar_out[i] = wide[SCALAR_WIDTH] ? SMIN : SMAX;
            end
            else
            begin
                scalar_out[i] = wide[SCALAR_WIDTH-1:0];
            end
        end
    end

    assign saturated = |lane_sat;

endmodule

// ----- rtl/selling_reflect_reduce.sv -----
// ============================================================================
// selling_reflect_reduce: Selling reflection and reduction step unit
// Applies one of 24 scalar permutations or one of six saturating reduction
// steps to an S6 lattice vector held as six signed fixed-point scalars.
// ============================================================================
// The block takes one item per clock while the output side is ready and
// returns one result per item: the input register captures the accepted
// item, the lane adders settle between the input register and the result
// register, and the result register presents the result. Both stages hold
// under back-pressure, so a full pipeline keeps two items in flight while
// still accepting a new one whenever the result is taken.
// Reflections never saturate; the saturated flag is set when any lane of a
// reduction step was clipped to the scalar range.
module selling_reflect_reduce #(
    parameter int unsigned SCALAR_WIDTH = srr_pkg::SCALAR_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    srr_in_if.sink    in_ch,
    srr_out_if.source out_ch
);
    import srr_pkg::*;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    opcode_t                        s1_opcode_reg;
    logic signed [SCALAR_WIDTH-1:0] s1_scalar_reg [NUM_SCALARS];

    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    logic signed [SCALAR_WIDTH-1:0] s2_scalar_reg [NUM_SCALARS];
    logic                           s2_sat_reg;

    logic signed [SCALAR_WIDTH-1:0] step_scalar [NUM_SCALARS];
    logic                           step_sat;
    logic                           s1_load;
    logic                           s2_load;

    // The result stage loads a pending item when it is empty or being emptied;
    // the input stage loads when it is empty or moving on.
    assign s2_load = s1_valid_reg && (!s2_valid_reg || out_ch.ready);
    assign s1_load = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s2_load;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load || (s2_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_opcode_reg    <= in_ch.opcode;
            s1_scalar_reg[0] <= in_ch.scalar_in_0;
            s1_scalar_reg[1] <= in_ch.scalar_in_1;
            s1_scalar_reg[2] <= in_ch.scalar_in_2;
            s1_scalar_reg[3] <= in_ch.scalar_in_3;
            s1_scalar_reg[4] <= in_ch.scalar_in_4;
            s1_scalar_reg[5] <= in_ch.scalar_in_5;
        end
        if (s2_load)
        begin
            s2_scalar_reg <= step_scalar;
            s2_sat_reg    <= step_sat;
        end
    end

    srr_step #(
        .SCALAR_WIDTH (SCALAR_WIDTH)
    ) u_step (
        .opcode     (s1_opcode_reg),
        .scalar_in  (s1_scalar_reg),
        .scalar_out (step_scalar),
        .saturated  (step_sat)
    );

    assign out_ch.valid        = s2_valid_reg;
    assign out_ch.scalar_out_0 = s2_scalar_reg[0];
    assign out_ch.scalar_out_1 = s2_scalar_reg[1];
    assign out_ch.scalar_out_2 = s2_scalar_reg[2];
    assign out_ch.scalar_out_3 = s2_scalar_reg[3];
    assign out_ch.scalar_out_4 = s2_scalar_reg[4];
    assign out_ch.scalar_out_5 = s2_scalar_reg[5];
    assign out_ch.saturated    = s2_sat_reg;

    // A pending item always moves into an empty result stage.
    a_advance_into_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_valid_reg |=> s2_valid_reg
    ) else $error("pending item did not advance into empty result stage");

    // A taken result with nothing behind it leaves the output empty.
    a_no_duplicate: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !s1_valid_reg |=> !out_ch.valid
    ) else $error("result presented twice");

    // While the output stalls, the item in the input stage stays put.
    a_hold_under_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && !out_ch.ready
            |=> s1_valid_reg && $stable(s1_opcode_reg) && $stable(s1_scalar_reg[0])
    ) else $error("input stage item lost under back-pressure");

    // Reflections and unused opcodes never clip.
    a_sat_only_on_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_load && (s1_opcode_reg < OPC_STEP_FIRST || s1_opcode_reg > OPC_STEP_LAST)
            |=> !s2_sat_reg
    ) else $error("saturation reported for a permutation");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench of selling_reflect_reduce
// A short table of directed vectors covers the scalar extremes, the unused
// opcodes and saturation on each reduction step. Several hundred random
// vectors follow under four idle and stall mixes and one long output hold.
// Every returned item is compared with a hand-written expected value or an
// independent model of the reflections and the saturating reduction steps.
// ============================================================================
module tb;

    import srr_pkg::*;

    localparam int unsigned SW           = SCALAR_WIDTH_DEF;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          TIMEOUT_NS   = 1_000_000;
    localparam int          PHASE_ITEMS  = 150;

    typedef logic signed [SW-1:0] scalar_t;

    typedef struct {
        opcode_t opcode;
        scalar_t s [NUM_SCALARS];
    } vector_in_t;

    typedef struct {
        scalar_t s [NUM_SCALARS];
        logic    saturated;
    } vector_out_t;

    typedef struct {
        vector_in_t  vec;
        bit          typed;
        vector_out_t want;
    } stim_row_t;

    localparam scalar_t SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam scalar_t SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam scalar_t ONE  = scalar_t'(32'sh0001_0000);

    localparam opcode_t OPC_REFL_FIRST = opcode_t'(0);
    localparam opcode_t OPC_REFL_LAST  = opcode_t'(NUM_REFLECT - 1);
    localparam opcode_t OPC_STEP1      = OPC_STEP_FIRST;
    localparam opcode_t OPC_STEP2      = OPC_STEP_FIRST + opcode_t'(1);
    localparam opcode_t OPC_STEP3      = OPC_STEP_FIRST + opcode_t'(2);
    localparam opcode_t OPC_STEP4      = OPC_STEP_FIRST + opcode_t'(3);
    localparam opcode_t OPC_STEP5      = OPC_STEP_FIRST + opcode_t'(4);
    localparam opcode_t OPC_STEP6      = OPC_STEP_LAST;
    localparam opcode_t OPC_SPARE_A    = OPC_STEP_LAST + opcode_t'(1);
    localparam opcode_t OPC_SPARE_B    = OPC_STEP_LAST + opcode_t'(2);

    // Source scalar of each output position, one row per reflection.
    localparam int REFL_SRC [NUM_REFLECT][NUM_SCALARS] = '{
        '{0, 1, 2, 3, 4, 5}, '{4, 3, 2, 1, 0, 5}, '{0, 2, 1, 3, 5, 4},
        '{5, 3, 1, 2, 0, 4}, '{4, 2, 3, 1, 5, 0}, '{5, 1, 3, 2, 4, 0},
        '{1, 0, 2, 4, 3, 5}, '{3, 4, 2, 0, 1, 5}, '{1, 2, 0, 4, 5, 3},
        '{5, 4, 0, 2, 1, 3}, '{3, 2, 4, 0, 5, 1}, '{5, 0, 4, 2, 3, 1},
        '{2, 0, 1, 5, 3, 4}, '{3, 5, 1, 0, 2, 4}, '{2, 1, 0, 5, 4, 3},
        '{4, 5, 0, 1, 2, 3}, '{3, 1, 5, 0, 4, 2}, '{4, 0, 5, 1, 3, 2},
        '{2, 4, 3, 5, 1, 0}, '{1, 5, 3, 4, 2, 0}, '{2, 3, 4, 5, 0, 1},
        '{0, 5, 4, 3, 2, 1}, '{1, 3, 5, 4, 0, 2}, '{0, 4, 5, 3, 1, 2}
    };

    logic clk;
    logic rst_n;

    srr_in_if  #(.SCALAR_WIDTH(SW)) in_ch ();
    srr_out_if #(.SCALAR_WIDTH(SW)) out_ch ();

    selling_reflect_reduce #(
        .SCALAR_WIDTH(SW)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    vector_out_t vectors_in_flight [$];
    stim_row_t   directed_rows [$];

    int        src_idle_pct   = 0;
    int        sink_stall_pct = 0;
    int        hold_requests  = 0;
    int        n_fail         = 0;
    int        vectors_sent   = 0;
    int        vectors_back   = 0;
    int        clipped_back   = 0;
    bit [31:0] opcodes_seen   = '0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------
    function automatic scalar_t clamp_sum(input logic signed [SW:0] wide, inout bit clip);
        if (wide[SW] != wide[SW-1])
        begin
            clip = 1'b1;
            return wide[SW] ? SMIN : SMAX;
        end
        return wide[SW-1:0];
    endfunction

    function automatic scalar_t sat_add(input scalar_t a, input scalar_t b, inout bit clip);
        return clamp_sum({a[SW-1], a} + {b[SW-1], b}, clip);
    endfunction

    function automatic scalar_t sat_sub(input scalar_t a, input scalar_t b, inout bit clip);
        return clamp_sum({a[SW-1], a} - {b[SW-1], b}, clip);
    endfunction

    function automatic scalar_t sat_neg(input scalar_t a, inout bit clip);
        return sat_sub('0, a, clip);
    endfunction

    function automatic vector_out_t reflect_or_reduce(input vector_in_t v);
        vector_out_t r;
        scalar_t     s [NUM_SCALARS];
        bit          clip;
        clip = 1'b0;
        s    = v.s;
        r.s  = v.s;
        if (v.opcode <= OPC_REFL_LAST)
        begin
            for (int k = 0; k < NUM_SCALARS; k++)
                r.s[k] = s[REFL_SRC[v.opcode][k]];
        end
        else
        begin
            case (v.opcode)
                OPC_STEP1:
                begin
                    r.s[0] = sat_neg(s[0], clip);
                    r.s[1] = sat_add(s[1], s[0], clip);
                    r.s[2] = sat_add(s[4], s[0], clip);
                    r.s[3] = sat_sub(s[3], s[0], clip);
                    r.s[4] = sat_add(s[2], s[0], clip);
                    r.s[5] = sat_add(s[5], s[0], clip);
                end
                OPC_STEP2:
                begin
                    r.s[0] = sat_sub(s[0], s[3], clip);
                    r.s[1] = sat_add(s[1], s[3], clip);
                    r.s[2] = sat_add(s[4], s[3], clip);
                    r.s[3] = sat_neg(s[3], clip);
                    r.s[4] = sat_add(s[2], s[3], clip);
                    r.s[5] = sat_add(s[5], s[3], clip);
                end
                OPC_STEP3:
                begin
                    r.s[0] = sat_add(s[0], s[1], clip);
                    r.s[1] = sat_neg(s[1], clip);
                    r.s[2] = sat_add(s[3], s[1], clip);
                    r.s[3] = sat_add(s[2], s[1], clip);
                    r.s[4] = sat_sub(s[4], s[1], clip);
                    r.s[5] = sat_add(s[5], s[1], clip);
                end
                OPC_STEP4:
                begin
                    r.s[0] = sat_add(s[0], s[4], clip);
                    r.s[1] = sat_sub(s[1], s[4], clip);
                    r.s[2] = sat_add(s[3], s[4], clip);
                    r.s[3] = sat_add(s[2], s[4], clip);
                    r.s[4] = sat_neg(s[4], clip);
                    r.s[5] = sat_add(s[5], s[4], clip);
                end
                OPC_STEP5:
                begin
                    r.s[0] = sat_add(s[0], s[2], clip);
                    r.s[1] = sat_add(s[3], s[2], clip);
                    r.s[2] = sat_neg(s[2], clip);
                    r.s[3] = sat_add(s[1], s[2], clip);
                    r.s[4] = sat_add(s[4], s[2], clip);
                    r.s[5] = sat_sub(s[5], s[2], clip);
                end
                OPC_STEP6:
                begin
                    r.s[0] = sat_add(s[0], s[5], clip);
                    r.s[1] = sat_add(s[3], s[5], clip);
                    r.s[2] = sat_sub(s[2], s[5], clip);
                    r.s[3] = sat_add(s[1], s[5], clip);
                    r.s[4] = sat_add(s[4], s[5], clip);
                    r.s[5] = sat_neg(s[5], clip);
                end
                default:
                begin
                    // The two spare opcodes leave the vector as it is.
                end
            endcase
        end
        r.saturated = clip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic vector_in_t vec(input opcode_t op, input scalar_t a, input scalar_t b,
                                       input scalar_t c, input scalar_t d, input scalar_t e,
                                       input scalar_t f);
        vector_in_t v;
        v.opcode = op;
        v.s      = '{a, b, c, d, e, f};
        return v;
    endfunction

    function automatic vector_out_t res(input scalar_t a, input scalar_t b, input scalar_t c,
                                        input scalar_t d, input scalar_t e, input scalar_t f,
                                        input logic sat);
        vector_out_t r;
        r.s         = '{a, b, c, d, e, f};
        r.saturated = sat;
        return r;
    endfunction

    task automatic add_row(input vector_in_t v, input bit typed, input vector_out_t want);
        stim_row_t row;
        row.vec   = v;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic scalar_t rand_scalar();
        case ($urandom_range(7))
            0:       return SMAX;
            1:       return SMIN;
            2:       return scalar_t'(int'($urandom_range(8)) - 4);
            3:       return SMAX - scalar_t'($urandom_range(255));
            4:       return SMIN + scalar_t'($urandom_range(255));
            default: return scalar_t'($urandom);
        endcase
    endfunction

    function automatic vector_in_t random_vector();
        vector_in_t v;
        // At least half the items go to the reduction steps, where the adders live.
        if ($urandom_range(1) == 0)
            v.opcode = OPC_STEP_FIRST + opcode_t'($urandom_range(NUM_STEPS - 1));
        else
            v.opcode = opcode_t'($urandom_range(31));
        for (int k = 0; k < NUM_SCALARS; k++)
            v.s[k] = rand_scalar();
        return v;
    endfunction

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_vector(input vector_in_t v, input bit typed, input vector_out_t want);
        vector_out_t expected;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= v.opcode;
        in_ch.scalar_in_0 <= v.s[0];
        in_ch.scalar_in_1 <= v.s[1];
        in_ch.scalar_in_2 <= v.s[2];
        in_ch.scalar_in_3 <= v.s[3];
        in_ch.scalar_in_4 <= v.s[4];
        in_ch.scalar_in_5 <= v.s[5];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (typed)
            expected = want;
        else
            expected = reflect_or_reduce(v);
        vectors_in_flight.insert(vectors_in_flight.size(), expected);
        vectors_sent++;
        opcodes_seen[v.opcode] = 1'b1;
    endtask

    task automatic wait_all_returned();
        in_ch.valid <= 1'b0;
        while (vectors_in_flight.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and the long hold
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        vector_out_t got;
        vector_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.s[0]      = out_ch.scalar_out_0;
            got.s[1]      = out_ch.scalar_out_1;
            got.s[2]      = out_ch.scalar_out_2;
            got.s[3]      = out_ch.scalar_out_3;
            got.s[4]      = out_ch.scalar_out_4;
            got.s[5]      = out_ch.scalar_out_5;
            got.saturated = out_ch.saturated;
            if (vectors_in_flight.size() == 0)
            begin
                $error("unexpected item on the output channel");
                n_fail++;
            end
            else
            begin
                want = vectors_in_flight.pop_front();
                vectors_back++;
                if (got.saturated === 1'b1)
                    clipped_back++;
                for (int k = 0; k < NUM_SCALARS; k++)
                begin
                    if (got.s[k] !== want.s[k])
                    begin
                        $error("scalar_out_%0d: expected %0d, got %0d", k, want.s[k], got.s[k]);
                        n_fail++;
                    end
                end
                if (got.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        vector_out_t none;
        none = res('0, '0, '0, '0, '0, '0, 1'b0);

        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OPC_REFL_FIRST;
        in_ch.scalar_in_0 <= '0;
        in_ch.scalar_in_1 <= '0;
        in_ch.scalar_in_2 <= '0;
        in_ch.scalar_in_3 <= '0;
        in_ch.scalar_in_4 <= '0;
        in_ch.scalar_in_5 <= '0;

        // Identity reflection, spare opcodes and extremes read off directly.
        add_row(vec(OPC_REFL_FIRST, 1, 2, 3, 4, 5, 6), 1'b1, res(1, 2, 3, 4, 5, 6, 1'b0));
        add_row(vec(OPC_SPARE_A, SMAX, SMIN, 0, -1, 1, 32'sh1234_5678), 1'b1,
                res(SMAX, SMIN, 0, -1, 1, 32'sh1234_5678, 1'b0));
        add_row(vec(OPC_SPARE_B, SMIN, SMAX, -1, 0, 32'sh7fff_0000, -ONE), 1'b1,
                res(SMIN, SMAX, -1, 0, 32'sh7fff_0000, -ONE, 1'b0));
        add_row(vec(OPC_REFL_LAST, SMAX, SMIN, 0, -1, 1, 2), 1'b1,
                res(SMAX, 1, 2, -1, SMIN, 0, 1'b0));
        // Negating the most negative value clips to the maximum.
        add_row(vec(OPC_STEP1, SMIN, 0, 0, 0, 0, 0), 1'b1,
                res(SMAX, SMIN, SMIN, SMAX, SMIN, SMIN, 1'b1));
        add_row(vec(OPC_STEP1, 0, 0, 0, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0, 1'b0));
        add_row(vec(opcode_t'(1), 11, 22, 33, 44, 55, 66), 1'b0, none);
        add_row(vec(opcode_t'(12), 11, 22, 33, 44, 55, 66), 1'b0, none);
        add_row(vec(OPC_STEP1, 3*ONE, -ONE, 2*ONE, ONE, -5*ONE, 7), 1'b0, none);
        add_row(vec(OPC_STEP2, 3*ONE, -ONE, 2*ONE, ONE, -5*ONE, 7), 1'b0, none);
        add_row(vec(OPC_STEP3, 3*ONE, -ONE, 2*ONE, ONE, -5*ONE, 7), 1'b0, none);
        add_row(vec(OPC_STEP4, 3*ONE, -ONE, 2*ONE, ONE, -5*ONE, 7), 1'b0, none);
        add_row(vec(OPC_STEP5, 3*ONE, -ONE, 2*ONE, ONE, -5*ONE, 7), 1'b0, none);
        add_row(vec(OPC_STEP6, 3*ONE, -ONE, 2*ONE, ONE, -5*ONE, 7), 1'b0, none);
        add_row(vec(OPC_STEP2, 5, 6, 7, SMIN, 8, 9), 1'b0, none);
        add_row(vec(OPC_STEP3, 5, SMIN, 7, 8, 9, 10), 1'b0, none);
        add_row(vec(OPC_STEP4, 5, 6, 7, 8, SMIN, 10), 1'b0, none);
        add_row(vec(OPC_STEP5, 5, 6, SMIN, 8, 9, 10), 1'b0, none);
        add_row(vec(OPC_STEP6, 5, 6, 7, 8, 9, SMIN), 1'b0, none);
        add_row(vec(OPC_STEP2, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX), 1'b0, none);
        add_row(vec(OPC_STEP4, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN), 1'b0, none);
        add_row(vec(OPC_STEP6, SMAX, SMIN, SMAX, SMIN, -1, SMIN), 1'b0, none);
        add_row(vec(OPC_STEP3, SMAX, SMIN, -1, 1, SMAX, SMIN), 1'b0, none);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_vector(directed_rows[i].vec, directed_rows[i].typed, directed_rows[i].want);
        wait_all_returned();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 27; sink_stall_pct = 27; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Midway through the first phase the output side holds off
                // while items keep coming, so the pipeline fills and stalls.
                if (phase == 0 && n == PHASE_ITEMS / 2)
                    hold_requests++;
                send_vector(random_vector(), 1'b0, none);
            end
            wait_all_returned();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d items sent covering %0d of 32 opcodes, %0d returned, %0d clipped",
                 vectors_sent, $countones(opcodes_seen), vectors_back, clipped_back);
        $display("summary: directed extremes, four idle/stall mixes, one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
